[hw/rtl/cta_pkg.sv]
// Package: shared types, constants and helpers of the calendar time adder.
`default_nettype none

package cta_pkg;

    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 16;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int ADD_W    = 16;
    localparam int DAYS_W   = 7;   // day sum before month carry, up to 77

    // Shared divider: dividend covers minute + add (up to 65594)
    localparam int DIV_W     = 17;
    localparam int DIVISOR_W = 6;

    // Reciprocals ceil(2^23 / d): exact quotients for every 17-bit dividend
    localparam int                 RECIP_W     = 19;
    localparam int                 RECIP_SHIFT = 23;
    localparam logic [RECIP_W-1:0] RECIP_60    = 19'd139811;
    localparam logic [RECIP_W-1:0] RECIP_24    = 19'd349526;
    localparam logic [RECIP_W-1:0] RECIP_25    = 19'd335545;

    localparam logic [DIVISOR_W-1:0] MIN_PER_HOUR = 6'd60;
    localparam logic [DIVISOR_W-1:0] HOUR_PER_DAY = 6'd24;
    // year % 25 together with the low year bits settles the leap rule
    localparam logic [DIVISOR_W-1:0] LEAP_DIVISOR = 6'd25;

    localparam logic [HOUR_W-1:0]   HOUR_MAX   = 5'd23;
    localparam logic [MINUTE_W-1:0] MINUTE_MAX = 6'd59;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [DAY_W-1:0] LEN_SHORT_FEB = 5'd28;
    localparam logic [DAY_W-1:0] LEN_LEAP_FEB  = 5'd29;
    localparam logic [DAY_W-1:0] LEN_30        = 5'd30;
    localparam logic [DAY_W-1:0] LEN_31        = 5'd31;
    localparam logic [DAY_W-1:0] DAY_FIRST     = 5'd1;

    localparam logic [MINUTE_W-1:0] RESET_MINUTE = 6'd0;
    localparam logic [HOUR_W-1:0]   RESET_HOUR   = 5'd0;
    localparam logic [DAY_W-1:0]    RESET_DAY    = 5'd1;
    localparam logic [MONTH_W-1:0]  RESET_MONTH  = 4'd1;
    localparam logic [YEAR_W-1:0]   RESET_YEAR   = 16'd2000;
    localparam logic                RESET_LEAP   = 1'b1;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_ADD  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_LEAP,
        ST_ADD_MIN,
        ST_ADD_HOUR,
        ST_DAY_STEP,
        ST_YEAR_LEAP,
        ST_DONE
    } cta_state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     dividend;
        logic [DIVISOR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_W-1:0]     quot;
        logic [DIVISOR_W-1:0] rem;
    } div_rsp_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (month) inside
            MONTH_FEB:                               len = leap ? LEN_LEAP_FEB : LEN_SHORT_FEB;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_30;
            default:                                 len = LEN_31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/cta_if.sv]
// Interfaces: command and response channels of the calendar time adder.
`default_nettype none

interface cta_cmd_if;
    import cta_pkg::*;

    logic                valid;
    logic                ready;
    logic                req_type;
    logic [ADD_W-1:0]    add_minutes;
    logic [DAY_W-1:0]    load_day;
    logic [MONTH_W-1:0]  load_month;
    logic [YEAR_W-1:0]   load_year;
    logic [HOUR_W-1:0]   load_hour;
    logic [MINUTE_W-1:0] load_minute;

    modport source (
        output valid, req_type, add_minutes, load_day, load_month, load_year,
               load_hour, load_minute,
        input  ready
    );

    modport sink (
        input  valid, req_type, add_minutes, load_day, load_month, load_year,
               load_hour, load_minute,
        output ready
    );
endinterface

interface cta_rsp_if;
    import cta_pkg::*;

    logic                valid;
    logic                ready;
    logic [DAY_W-1:0]    out_day;
    logic [MONTH_W-1:0]  out_month;
    logic [YEAR_W-1:0]   out_year;
    logic [HOUR_W-1:0]   out_hour;
    logic [MINUTE_W-1:0] out_minute;
    logic                leap_flag;
    logic [DAY_W-1:0]    month_length;

    modport source (
        output valid, out_day, out_month, out_year, out_hour, out_minute,
               leap_flag, month_length,
        input  ready
    );

    modport sink (
        input  valid, out_day, out_month, out_year, out_hour, out_minute,
               leap_flag, month_length,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/cta_divider.sv]
// Shared constant divider: reciprocal multiply for the quotient, multiply back for the remainder.
`default_nettype none

module cta_divider (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cta_pkg::div_req_t req,
    output cta_pkg::div_rsp_t      rsp
);
    import cta_pkg::*;

    localparam int PROD_W = DIV_W + RECIP_W;

    logic                 stage_reg, stage_next;
    logic                 done_reg, done_next;
    logic [DIV_W-1:0]     dividend_reg, dividend_next;
    logic [DIVISOR_W-1:0] divisor_reg, divisor_next;
    logic [DIV_W-1:0]     quot_reg, quot_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;

    logic [RECIP_W-1:0]   recip;
    logic [PROD_W-1:0]    product;
    logic [DIV_W-1:0]     back;

    always_comb
    begin
        // serve the three calendar divisors only
        case (req.divisor)
            MIN_PER_HOUR: recip = RECIP_60;
            HOUR_PER_DAY: recip = RECIP_24;
            LEAP_DIVISOR: recip = RECIP_25;
            default:      recip = '0;
        endcase
        product = PROD_W'(req.dividend) * PROD_W'(recip);
        back    = quot_reg * DIV_W'(divisor_reg);

        stage_next    = req.start;
        done_next     = stage_reg;
        dividend_next = dividend_reg;
        divisor_next  = divisor_reg;
        quot_next     = quot_reg;
        rem_next      = rem_reg;

        if (req.start)
        begin
            // first step: quotient from the scaled reciprocal
            dividend_next = req.dividend;
            divisor_next  = req.divisor;
            quot_next     = DIV_W'(product >> RECIP_SHIFT);
        end
        if (stage_reg)
        begin
            // second step: remainder from the quotient
            rem_next = DIVISOR_W'(dividend_reg - back);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= stage_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dividend_reg <= dividend_next;
        divisor_reg  <= divisor_next;
        quot_reg     <= quot_next;
        rem_reg      <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

`default_nettype wire

[hw/rtl/calendar_time_add_minutes.sv]
// Top level: Gregorian date and time keeper with load and add-minutes commands.
//
// Usage:
//   cmd channel (sink): one transfer per command. req_type selects a load of
//   day, month, year, hour and minute (out-of-range fields are clamped) or an
//   advance of the stored time by add_minutes (saturated at MAX_ADD_MINUTES).
//   rsp channel (source): exactly one transfer per command, carrying the date
//   and time after the update, the leap flag and the current month's length.
//
// Sequencing: one command at a time; cmd.ready is high only while the
// sequencer idles. The shared divider (reciprocal multiply, then multiply
// back) runs once for a load (year mod 25 for the leap rule), twice for an
// add (by 60, then by 24) and once more per new year; an add also steps
// through the months crossed one at a time.
//
// Reset: asynchronous, active low; the clock reads 2000-01-01 00:00, no result
// is pending. Stall: the result sits in an output register; the next command
// is accepted while it waits, and a finished command holds in its last state
// until the register frees up.
`default_nettype none

module calendar_time_add_minutes #(
    parameter int MAX_ADD_MINUTES = 65535
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    cta_cmd_if.sink    cmd,
    cta_rsp_if.source  rsp
);
    import cta_pkg::*;

    localparam int SAT_W = ($clog2(MAX_ADD_MINUTES + 1) > ADD_W) ?
                           $clog2(MAX_ADD_MINUTES + 1) : ADD_W;

    cta_state_t state_reg, state_next;

    logic [MINUTE_W-1:0] cur_minute_reg, cur_minute_next;
    logic [HOUR_W-1:0]   cur_hour_reg, cur_hour_next;
    logic [DAY_W-1:0]    cur_day_reg, cur_day_next;
    logic [MONTH_W-1:0]  cur_month_reg, cur_month_next;
    logic [YEAR_W-1:0]   cur_year_reg, cur_year_next;
    logic                leap_reg, leap_next;
    logic [DAYS_W-1:0]   days_reg, days_next;

    logic                rsp_valid_reg, rsp_valid_next;
    logic [DAY_W-1:0]    out_day_reg;
    logic [MONTH_W-1:0]  out_month_reg;
    logic [YEAR_W-1:0]   out_year_reg;
    logic [HOUR_W-1:0]   out_hour_reg;
    logic [MINUTE_W-1:0] out_minute_reg;
    logic                out_leap_reg;
    logic [DAY_W-1:0]    out_len_reg;

    div_req_t            div_req;
    div_rsp_t            div_rsp;

    logic                cmd_fire;
    logic                out_free;
    logic                out_load;
    logic                leap_calc;
    logic [DAY_W-1:0]    mlen_cur;
    logic [DAY_W-1:0]    mlen_calc;
    logic                day_carry;
    logic [ADD_W-1:0]    add_sat;

    cta_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign out_load  = (state_reg == ST_DONE) && out_free;

    // Leap rule from year mod 25: divisible by 4 and (not by 100 or by 400)
    assign leap_calc = (cur_year_reg[1:0] == 2'd0) &&
                       ((div_rsp.rem != '0) || (cur_year_reg[3:0] == 4'd0));
    assign mlen_cur  = month_len(cur_month_reg, leap_reg);
    assign mlen_calc = month_len(cur_month_reg, leap_calc);
    assign day_carry = (days_reg > DAYS_W'(mlen_cur));

    assign add_sat = (SAT_W'(cmd.add_minutes) > SAT_W'(MAX_ADD_MINUTES)) ?
                     ADD_W'(MAX_ADD_MINUTES) : cmd.add_minutes;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    state_next = (cmd.req_type == REQ_LOAD) ? ST_LOAD_LEAP : ST_ADD_MIN;
                end
            end
            ST_LOAD_LEAP:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_ADD_MIN:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_ADD_HOUR;
                end
            end
            ST_ADD_HOUR:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_DAY_STEP;
                end
            end
            ST_DAY_STEP:
            begin
                if (!day_carry)
                begin
                    state_next = ST_DONE;
                end
                else if (cur_month_reg == MONTH_DEC)
                begin
                    state_next = ST_YEAR_LEAP;
                end
            end
            ST_YEAR_LEAP:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_DAY_STEP;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath updates and divider requests
    always_comb
    begin
        cur_minute_next  = cur_minute_reg;
        cur_hour_next    = cur_hour_reg;
        cur_day_next     = cur_day_reg;
        cur_month_next   = cur_month_reg;
        cur_year_next    = cur_year_reg;
        leap_next        = leap_reg;
        days_next        = days_reg;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    if (cmd.req_type == REQ_LOAD)
                    begin
                        // clamp fields now, the day waits for the leap answer
                        if (cmd.load_month < MONTH_JAN)
                        begin
                            cur_month_next = MONTH_JAN;
                        end
                        else if (cmd.load_month > MONTH_DEC)
                        begin
                            cur_month_next = MONTH_DEC;
                        end
                        else
                        begin
                            cur_month_next = cmd.load_month;
                        end
                        cur_hour_next    = (cmd.load_hour > HOUR_MAX) ? HOUR_MAX : cmd.load_hour;
                        cur_minute_next  = (cmd.load_minute > MINUTE_MAX) ?
                                           MINUTE_MAX : cmd.load_minute;
                        cur_year_next    = cmd.load_year;
                        days_next        = DAYS_W'(cmd.load_day);
                        div_req.start    = 1'b1;
                        div_req.dividend = DIV_W'(cmd.load_year);
                        div_req.divisor  = LEAP_DIVISOR;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = DIV_W'(cur_minute_reg) + DIV_W'(add_sat);
                        div_req.divisor  = MIN_PER_HOUR;
                    end
                end
            end
            ST_LOAD_LEAP:
            begin
                if (div_rsp.done)
                begin
                    leap_next = leap_calc;
                    if (days_reg == '0)
                    begin
                        cur_day_next = DAY_FIRST;
                    end
                    else if (days_reg > DAYS_W'(mlen_calc))
                    begin
                        cur_day_next = mlen_calc;
                    end
                    else
                    begin
                        cur_day_next = days_reg[DAY_W-1:0];
                    end
                end
            end
            ST_ADD_MIN:
            begin
                if (div_rsp.done)
                begin
                    cur_minute_next  = div_rsp.rem;
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_W'(cur_hour_reg) + div_rsp.quot;
                    div_req.divisor  = HOUR_PER_DAY;
                end
            end
            ST_ADD_HOUR:
            begin
                if (div_rsp.done)
                begin
                    cur_hour_next = div_rsp.rem[HOUR_W-1:0];
                    days_next     = DAYS_W'(cur_day_reg) + div_rsp.quot[DAYS_W-1:0];
                end
            end
            ST_DAY_STEP:
            begin
                if (day_carry)
                begin
                    // drop one month's worth of days and advance the month
                    days_next = days_reg - DAYS_W'(mlen_cur);
                    if (cur_month_reg == MONTH_DEC)
                    begin
                        cur_month_next   = MONTH_JAN;
                        cur_year_next    = cur_year_reg + 1'b1;
                        div_req.start    = 1'b1;
                        div_req.dividend = DIV_W'(cur_year_next);
                        div_req.divisor  = LEAP_DIVISOR;
                    end
                    else
                    begin
                        cur_month_next = cur_month_reg + 1'b1;
                    end
                end
                else
                begin
                    cur_day_next = days_reg[DAY_W-1:0];
                end
            end
            ST_YEAR_LEAP:
            begin
                if (div_rsp.done)
                begin
                    leap_next = leap_calc;
                end
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Result register: hold until the receiver takes it
    assign rsp_valid_next = (rsp_valid_reg && !rsp.ready) || out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cur_minute_reg <= RESET_MINUTE;
            cur_hour_reg   <= RESET_HOUR;
            cur_day_reg    <= RESET_DAY;
            cur_month_reg  <= RESET_MONTH;
            cur_year_reg   <= RESET_YEAR;
            leap_reg       <= RESET_LEAP;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_minute_reg <= cur_minute_next;
            cur_hour_reg   <= cur_hour_next;
            cur_day_reg    <= cur_day_next;
            cur_month_reg  <= cur_month_next;
            cur_year_reg   <= cur_year_next;
            leap_reg       <= leap_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        days_reg <= days_next;
        if (out_load)
        begin
            out_day_reg    <= cur_day_reg;
            out_month_reg  <= cur_month_reg;
            out_year_reg   <= cur_year_reg;
            out_hour_reg   <= cur_hour_reg;
            out_minute_reg <= cur_minute_reg;
            out_leap_reg   <= leap_reg;
            out_len_reg    <= mlen_cur;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.out_day      = out_day_reg;
    assign rsp.out_month    = out_month_reg;
    assign rsp.out_year     = out_year_reg;
    assign rsp.out_hour     = out_hour_reg;
    assign rsp.out_minute   = out_minute_reg;
    assign rsp.leap_flag    = out_leap_reg;
    assign rsp.month_length = out_len_reg;

endmodule

`default_nettype wire

[hw/rtl/cta_checker.sv]
// Checker: port-level properties of the calendar time adder, bound to the top.
`default_nettype none

module cta_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       rsp_valid,
    input wire logic       rsp_ready,
    input wire logic [4:0] out_day,
    input wire logic [3:0] out_month,
    input wire logic [15:0] out_year,
    input wire logic [4:0] out_hour,
    input wire logic [5:0] out_minute,
    input wire logic       leap_flag,
    input wire logic [4:0] month_length
);
    import cta_pkg::*;

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (out_month >= MONTH_JAN) && (out_month <= MONTH_DEC) &&
                      (out_hour <= HOUR_MAX) && (out_minute <= MINUTE_MAX))
        else $error("time fields out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (out_day >= DAY_FIRST) && (out_day <= month_length))
        else $error("day outside current month");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((out_month == MONTH_FEB) &&
                       (month_length == (leap_flag ? LEN_LEAP_FEB : LEN_SHORT_FEB))) ||
                      ((out_month != MONTH_FEB) &&
                       ((month_length == LEN_30) || (month_length == LEN_31))))
        else $error("month length inconsistent with month and leap flag");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (out_year[1:0] != 2'd0) |-> !leap_flag)
        else $error("leap flag set for year not divisible by four");

endmodule

bind calendar_time_add_minutes cta_checker u_cta_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .out_day      (rsp.out_day),
    .out_month    (rsp.out_month),
    .out_year     (rsp.out_year),
    .out_hour     (rsp.out_hour),
    .out_minute   (rsp.out_minute),
    .leap_flag    (rsp.leap_flag),
    .month_length (rsp.month_length)
);

`default_nettype wire

[tb/calendar_time_add_minutes_tb.sv]
// Testbench: drives load and add-minutes commands and checks every returned date and time.
`timescale 1ns / 1ps

module calendar_time_add_minutes_tb;
    import cta_pkg::*;

    localparam int MAX_ADD   = 65535;
    localparam int RAND_CMDS = 1900;
    // Hold the response side off once, this many cycles, after this many responses.
    localparam int HOLD_AT     = 700;
    localparam int HOLD_CYCLES = 400;
    // Drain allowance: waited out after the last expected response arrives.
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic                req_type;
        logic [ADD_W-1:0]    add_minutes;
        logic [DAY_W-1:0]    load_day;
        logic [MONTH_W-1:0]  load_month;
        logic [YEAR_W-1:0]   load_year;
        logic [HOUR_W-1:0]   load_hour;
        logic [MINUTE_W-1:0] load_minute;
    } cal_cmd_t;

    typedef struct packed {
        logic [DAY_W-1:0]    day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic                leap;
        logic [DAY_W-1:0]    mlen;
    } cal_stamp_t;

    // One row of the directed script; typed_in rows carry a hand-written answer.
    typedef struct {
        cal_cmd_t   cmd;
        bit         typed_in;
        cal_stamp_t want;
    } script_row_t;

    logic clk;
    logic rst_n;

    cta_cmd_if cmd_ch ();
    cta_rsp_if rsp_ch ();

    calendar_time_add_minutes #(
        .MAX_ADD_MINUTES (MAX_ADD)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // Shadow copy of the calendar, advanced on every accepted command transfer.
    int unsigned now_minute = RESET_MINUTE;
    int unsigned now_hour   = RESET_HOUR;
    int unsigned now_day    = RESET_DAY;
    int unsigned now_month  = RESET_MONTH;
    int unsigned now_year   = RESET_YEAR;

    cal_stamp_t  pending_stamps[$];
    script_row_t script_rows[$];
    int          mismatch_cnt = 0;
    int          rsp_seen     = 0;
    // Set by the stimulus side during a stretch where neither side idles.
    bit          calm         = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Generous ceiling, several times the slowest legal run.
    initial
    begin
        #8_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic bit leap_year(input int unsigned y);
        if (y % 4 != 0) return 1'b0;
        if (y % 100 != 0) return 1'b1;
        return (y % 400) == 0;
    endfunction

    function automatic int unsigned days_in(input int unsigned m, input int unsigned y);
        if (m == MONTH_FEB) return leap_year(y) ? LEN_LEAP_FEB : LEN_SHORT_FEB;
        if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV)
            return LEN_30;
        return LEN_31;
    endfunction

    // Apply one command to the shadow calendar and return what the block must report.
    function automatic cal_stamp_t step_calendar(input cal_cmd_t c);
        int unsigned m, d, h, mi, add, total, hours, day_acc;
        cal_stamp_t  s;
        if (c.req_type == REQ_LOAD)
        begin
            // Clamp each loaded field into range; the day against the loaded month.
            m  = c.load_month;
            d  = c.load_day;
            h  = c.load_hour;
            mi = c.load_minute;
            if (m < MONTH_JAN) m = MONTH_JAN;
            if (m > MONTH_DEC) m = MONTH_DEC;
            if (d < DAY_FIRST) d = DAY_FIRST;
            if (d > days_in(m, c.load_year)) d = days_in(m, c.load_year);
            if (h > HOUR_MAX) h = HOUR_MAX;
            if (mi > MINUTE_MAX) mi = MINUTE_MAX;
            now_day    = d;
            now_month  = m;
            now_year   = c.load_year;
            now_hour   = h;
            now_minute = mi;
        end
        else
        begin
            add = c.add_minutes;
            if (add > MAX_ADD) add = MAX_ADD;
            total      = now_minute + add;
            now_minute = total % MIN_PER_HOUR;
            hours      = now_hour + total / MIN_PER_HOUR;
            now_hour   = hours % HOUR_PER_DAY;
            day_acc    = now_day + hours / HOUR_PER_DAY;
            // Roll days through as many months as needed; wrap the year past 65535.
            while (day_acc > days_in(now_month, now_year))
            begin
                day_acc   = day_acc - days_in(now_month, now_year);
                now_month = now_month + 1;
                if (now_month > MONTH_DEC)
                begin
                    now_month = MONTH_JAN;
                    now_year  = (now_year + 1) & 16'hFFFF;
                end
            end
            now_day = day_acc;
        end
        s.day    = now_day[DAY_W-1:0];
        s.month  = now_month[MONTH_W-1:0];
        s.year   = now_year[YEAR_W-1:0];
        s.hour   = now_hour[HOUR_W-1:0];
        s.minute = now_minute[MINUTE_W-1:0];
        s.leap   = leap_year(now_year);
        s.mlen   = DAY_W'(days_in(now_month, now_year));
        return s;
    endfunction

    // Loads carry all-ones in add_minutes, adds carry all-ones in the load fields:
    // both must be ignored.
    function automatic cal_cmd_t load_cmd(input int unsigned d, input int unsigned m,
                                          input int unsigned y, input int unsigned h,
                                          input int unsigned mi);
        cal_cmd_t c;
        c.req_type    = REQ_LOAD;
        c.add_minutes = '1;
        c.load_day    = d[DAY_W-1:0];
        c.load_month  = m[MONTH_W-1:0];
        c.load_year   = y[YEAR_W-1:0];
        c.load_hour   = h[HOUR_W-1:0];
        c.load_minute = mi[MINUTE_W-1:0];
        return c;
    endfunction

    function automatic cal_cmd_t add_cmd(input int unsigned n);
        cal_cmd_t c;
        c             = '1;
        c.req_type    = REQ_ADD;
        c.add_minutes = n[ADD_W-1:0];
        return c;
    endfunction

    function automatic cal_stamp_t stamp(input int unsigned d, input int unsigned m,
                                         input int unsigned y, input int unsigned h,
                                         input int unsigned mi, input bit lp,
                                         input int unsigned ml);
        cal_stamp_t s;
        s.day    = d[DAY_W-1:0];
        s.month  = m[MONTH_W-1:0];
        s.year   = y[YEAR_W-1:0];
        s.hour   = h[HOUR_W-1:0];
        s.minute = mi[MINUTE_W-1:0];
        s.leap   = lp;
        s.mlen   = ml[DAY_W-1:0];
        return s;
    endfunction

    task automatic add_row(input cal_cmd_t c, input bit typed_in, input cal_stamp_t want);
        script_row_t r;
        r.cmd      = c;
        r.typed_in = typed_in;
        r.want     = want;
        script_rows.push_back(r);
    endtask

    function automatic int unsigned pick_year();
        case ($urandom_range(5))
            0:       return 65535;
            1:       return 0;
            2:       return 100 * $urandom_range(0, 24);
            3:       return $urandom_range(1995, 2030);
            4:       return $urandom_range(65530, 65535);
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // Mostly adds, so the calendar keeps rolling; most loads land near month and year ends.
    function automatic cal_cmd_t random_cmd();
        cal_cmd_t    c;
        bit [31:0]   r;
        int unsigned n;
        r             = $urandom;
        c.add_minutes = r[ADD_W-1:0];
        r             = $urandom;
        c.load_year   = r[YEAR_W-1:0];
        r             = $urandom;
        c.load_day    = r[DAY_W-1:0];
        c.load_month  = r[DAY_W +: MONTH_W];
        c.load_hour   = r[12 +: HOUR_W];
        c.load_minute = r[20 +: MINUTE_W];
        c.req_type    = ($urandom_range(99) < 15) ? REQ_LOAD : REQ_ADD;
        if (c.req_type == REQ_LOAD)
        begin
            // Keep some loads fully random so the clamps see every raw value.
            if ($urandom_range(99) < 70)
            begin
                case ($urandom_range(3))
                    0:       c.load_month = MONTH_DEC;
                    1:       c.load_month = MONTH_FEB;
                    default: c.load_month = MONTH_W'($urandom_range(1, 12));
                endcase
                c.load_day    = DAY_W'($urandom_range(24, 31));
                c.load_year   = YEAR_W'(pick_year());
                c.load_hour   = HOUR_W'($urandom_range(0, 23));
                c.load_minute = MINUTE_W'($urandom_range(0, 59));
            end
        end
        else
        begin
            case ($urandom_range(2))
                0: ;
                1: c.add_minutes = ADD_W'($urandom_range(0, 200));
                default:
                begin
                    n             = 1440 * $urandom_range(1, 44) + $urandom_range(0, 30);
                    c.add_minutes = n[ADD_W-1:0];
                end
            endcase
        end
        return c;
    endfunction

    function automatic bit take_break();
        return !calm && ($urandom_range(99) < 35);
    endfunction

    // Offer one command, hold it until the transfer, then record its expected response.
    task automatic offer_cmd(input cal_cmd_t c, input bit typed_in, input cal_stamp_t want);
        cal_stamp_t p;
        while (take_break())
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.req_type    <= c.req_type;
        cmd_ch.add_minutes <= c.add_minutes;
        cmd_ch.load_day    <= c.load_day;
        cmd_ch.load_month  <= c.load_month;
        cmd_ch.load_year   <= c.load_year;
        cmd_ch.load_hour   <= c.load_hour;
        cmd_ch.load_minute <= c.load_minute;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        // Advance the shadow calendar even for typed-in rows, so it stays in step.
        p = step_calendar(c);
        pending_stamps.push_back(typed_in ? want : p);
    endtask

    // Response side: check each transfer, idle at random, and hold off once for a long stretch.
    initial
    begin
        int         hold_left;
        bit         hold_done;
        cal_stamp_t got;
        cal_stamp_t exp_s;
        hold_left = 0;
        hold_done = 1'b0;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.day    = rsp_ch.out_day;
                got.month  = rsp_ch.out_month;
                got.year   = rsp_ch.out_year;
                got.hour   = rsp_ch.out_hour;
                got.minute = rsp_ch.out_minute;
                got.leap   = rsp_ch.leap_flag;
                got.mlen   = rsp_ch.month_length;
                rsp_seen++;
                if (pending_stamps.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected response %0d-%0d-%0d %0d:%0d leap %0b len %0d",
                                 got.year, got.month, got.day, got.hour, got.minute,
                                 got.leap, got.mlen);
                end
                else
                begin
                    exp_s = pending_stamps.pop_front();
                    if (got.day !== exp_s.day || got.month !== exp_s.month ||
                        got.year !== exp_s.year || got.hour !== exp_s.hour ||
                        got.minute !== exp_s.minute || got.leap !== exp_s.leap ||
                        got.mlen !== exp_s.mlen)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display({"mismatch at response %0d: expected %0d-%0d-%0d ",
                                      "%0d:%0d leap %0b len %0d, got %0d-%0d-%0d %0d:%0d ",
                                      "leap %0b len %0d"},
                                     rsp_seen, exp_s.year, exp_s.month, exp_s.day,
                                     exp_s.hour, exp_s.minute, exp_s.leap, exp_s.mlen,
                                     got.year, got.month, got.day, got.hour, got.minute,
                                     got.leap, got.mlen);
                    end
                end
            end
            if (!hold_done && rsp_seen == HOLD_AT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= !take_break();
            end
        end
    end

    // Command side: reset, directed script, random commands, drain, verdict.
    initial
    begin
        int n;
        cmd_ch.valid       <= 1'b0;
        cmd_ch.req_type    <= REQ_LOAD;
        cmd_ch.add_minutes <= '0;
        cmd_ch.load_day    <= '0;
        cmd_ch.load_month  <= '0;
        cmd_ch.load_year   <= '0;
        cmd_ch.load_hour   <= '0;
        cmd_ch.load_minute <= '0;
        rst_n              <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset value, with a zero add.
        add_row(add_cmd(0), 1, stamp(1, 1, 2000, 0, 0, 1, 31));
        // Day, month, hour and minute all out of range at once: clamp all of them.
        add_row(load_cmd(0, 0, 1900, 31, 63), 1, stamp(1, 1, 1900, 23, 59, 0, 31));
        add_row(add_cmd(1), 1, stamp(2, 1, 1900, 0, 0, 0, 31));
        // Day clamped to February in a century non-leap year, then roll into March.
        add_row(load_cmd(31, 2, 1900, 12, 30), 1, stamp(28, 2, 1900, 12, 30, 0, 28));
        add_row(add_cmd(720), 0, '0);
        // Leap day by the 400 rule, then carry across it.
        add_row(load_cmd(31, 2, 2000, 23, 59), 1, stamp(29, 2, 2000, 23, 59, 1, 29));
        add_row(add_cmd(1), 0, '0);
        add_row(load_cmd(30, 2, 2024, 0, 0), 1, stamp(29, 2, 2024, 0, 0, 1, 29));
        add_row(load_cmd(29, 2, 2100, 0, 0), 1, stamp(28, 2, 2100, 0, 0, 0, 28));
        // Thirty-day month clamp, and month codes above December.
        add_row(load_cmd(31, 4, 2023, 5, 5), 1, stamp(30, 4, 2023, 5, 5, 0, 30));
        add_row(load_cmd(31, 15, 2023, 0, 0), 1, stamp(31, 12, 2023, 0, 0, 0, 31));
        // Last minute of the last year: one more minute wraps to year 0, a leap year.
        add_row(load_cmd(31, 12, 65535, 23, 59), 1, stamp(31, 12, 65535, 23, 59, 0, 31));
        add_row(add_cmd(1), 1, stamp(1, 1, 0, 0, 0, 1, 31));
        // Largest add from the start of a leap year.
        add_row(load_cmd(1, 1, 0, 0, 0), 0, '0);
        add_row(add_cmd(MAX_ADD), 0, '0);
        // Just-out-of-range hour and minute, month 13, day 0.
        add_row(load_cmd(0, 13, 2400, 24, 60), 1, stamp(1, 12, 2400, 23, 59, 1, 31));
        add_row(add_cmd(MAX_ADD), 0, '0);
        // Largest add across the year wrap.
        add_row(load_cmd(15, 12, 65535, 10, 0), 0, '0);
        add_row(add_cmd(MAX_ADD), 0, '0);
        // Add 29 days from the end of January: through a short February, onto a leap day.
        add_row(load_cmd(31, 1, 2001, 0, 0), 0, '0);
        add_row(add_cmd(41760), 0, '0);
        add_row(load_cmd(31, 1, 2004, 6, 0), 0, '0);
        add_row(add_cmd(41760), 0, '0);
        // Minute and hour carry edges.
        add_row(add_cmd(59), 0, '0);
        add_row(add_cmd(1439), 0, '0);

        foreach (script_rows[i])
            offer_cmd(script_rows[i].cmd, script_rows[i].typed_in, script_rows[i].want);

        for (n = 0; n < RAND_CMDS; n++)
        begin
            // No idling in this window; the response hold-off falls inside it.
            calm = (n >= 500 && n < 900);
            offer_cmd(random_cmd(), 0, '0);
        end
        cmd_ch.valid <= 1'b0;

        // Drain, then give a stray response time to show up.
        while (pending_stamps.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0 && pending_stamps.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[calendar_time_add_minutes.f]
hw/rtl/cta_pkg.sv
hw/rtl/cta_if.sv
hw/rtl/cta_divider.sv
hw/rtl/calendar_time_add_minutes.sv
hw/rtl/cta_checker.sv
tb/calendar_time_add_minutes_tb.sv
